[rtl/core/assert_macros.svh]
// Assertion macros shared by the pulse train gate RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define PTEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define PTEG_ASSERT_IMP(label, ante, cons, msg) \
    `PTEG_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PTEG_ASSERT_NEXT(label, ante, cons, msg) \
    `PTEG_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/core/pteg_pkg.sv]
// Package for the pulse train envelope gate: default widths, register reset values,
// register indexes, controller states and the command/status structs. No dependencies.
package pteg_pkg;

    // Default widths of the sample path and the frame counters.
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_COUNT_BITS   = 20;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int PULSE_COUNT_BITS = 8;

    // Register values after reset.
    localparam int RST_START_OFFSET = 0;
    localparam int RST_PULSE_LEN    = 3840;
    localparam int RST_PAUSE_LEN    = 960;
    localparam int RST_FADE_LEN     = 480;
    localparam int RST_PULSE_COUNT  = 5;
    localparam int RST_TOTAL_FRAMES = 48000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_START_OFFSET = 3'd0,
        REG_PULSE_LEN    = 3'd1,
        REG_PAUSE_LEN    = 3'd2,
        REG_FADE_LEN     = 3'd3,
        REG_PULSE_COUNT  = 3'd4,
        REG_TOTAL_FRAMES = 3'd5
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_POS_DIV,
        ST_POS_EVAL,
        ST_FADE_IN,
        ST_FADE_OUT,
        ST_MUL,
        ST_GAIN_LOAD,
        ST_GAIN_DIV,
        ST_GAIN_STORE,
        ST_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic classify;
        logic div_step;
        logic eval;
        logic mul;
        logic sel_k2;
        logic gain_load;
        logic gain_store;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic need_in;
        logic need_out;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/pulse_train_envelope_gate_unit.sv]
// Pulse train envelope gate: one audio channel gated into faded pulses.
// Top level; instantiates pteg_ctrl and pteg_datapath, uses pteg_pkg.
//
// Usage:
//   Input beats (sample, restart) enter on in_valid/in_stall; a beat is taken at
//   an edge with in_valid high and in_stall low. restart marks frame zero.
//   Each input beat yields exactly one output beat (shaped_sample, gate_open)
//   on out_valid/out_stall; it is taken at an edge with out_valid high and
//   out_stall low.
//   Registers are written on cfg_valid/cfg_ready (cfg_ready is always high),
//   cfg_index 0..5 selects the register; other indexes are ignored. Write them
//   only while no beat is in flight.
//   Operation: a beat is worked on alone. Silent and pass-through frames skip the
//   divisions; other frames inside the buffer past the start go through the
//   bit-serial position division, then one bit-serial gain division for each
//   fade gain that applies.
//   A finished result waits in the output register while out_stall is high;
//   the next beat is still accepted and worked on, and held before handoff.
//   Reset clears the frame counter, empties the output and loads default registers.

module pulse_train_envelope_gate_unit
    import pteg_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COUNT_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] shaped_sample,
    output logic                          gate_open
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    pteg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    pteg_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .restart       (restart),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .shaped_sample (shaped_sample),
        .gate_open     (gate_open)
    );

endmodule

[rtl/core/pteg_datapath.sv]
// Datapath of the pulse train gate: configuration registers, frame counter,
// shared restoring divider, gain multiplier and output register. Uses pteg_pkg.
`include "assert_macros.svh"

module pteg_datapath
    import pteg_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COUNT_BITS-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] shaped_sample,
    output logic                          gate_open
);

    localparam int SB = SAMPLE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int DW = SB + CB;
    localparam int QW = (SB > CB) ? SB : CB;
    localparam int CW = $clog2(QW + 1);

    // Configuration registers.
    logic [CB-1:0]               start_reg;
    logic [CB-1:0]               pulse_reg;
    logic [CB-1:0]               pause_reg;
    logic [CB-1:0]               fade_reg;
    logic [PULSE_COUNT_BITS-1:0] count_reg;
    logic [CB-1:0]               total_reg;

    // Frame counter and per-beat working registers.
    logic [CB-1:0] frame_pos_reg;
    logic [CB-1:0] frame_pos_next;
    logic [CB-1:0] p_reg;
    logic [SB-1:0] samp_reg;
    logic [SB-1:0] cur_reg;
    logic          gate_reg;
    logic [CB-1:0] k_reg;
    logic [CB-1:0] k2_reg;
    logic          apply_in_reg;
    logic          apply_out_reg;
    logic [DW-1:0] prod_reg;
    logic          neg_reg;

    // Divider registers.
    logic [CB:0]   rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [CB:0]   divisor_reg;

    // Output register.
    logic [SB-1:0] shaped_reg;
    logic          gate_out_reg;
    logic          out_valid_reg;

    // Combinational terms.
    logic [CB-1:0] p_in;
    logic          in_buf;
    logic          fade_long;
    logic          before_start;
    logic [CB:0]   period;
    logic          need_div;
    logic [CB-1:0] frame_offset;
    logic [CB+1:0] trial;
    logic [CB+1:0] trial_diff;
    logic          trial_ge;
    logic [CB:0]   rem_step;
    logic [CB-1:0] idx;
    logic          idx_ok;
    logic [CB-1:0] phase_lo;
    logic [CB-1:0] start_pos;
    logic [CB:0]   end_sum;
    logic          clip;
    logic [CB:0]   end_pos;
    logic          open_gate;
    logic [CB:0]   k2_full;
    logic [CB-1:0] gain_k;
    logic [SB-1:0] mag;
    logic [DW-1:0] prod_full;
    logic [SB-1:0] quo_lo;
    logic [SB-1:0] gain_res;

    // Frame number of the incoming beat and the saturating advance.
    assign p_in           = restart ? '0 : frame_pos_reg;
    assign frame_pos_next = (p_in == {CB{1'b1}}) ? p_in : p_in + CB'(1);

    // Classification of the captured frame.
    assign in_buf       = p_reg < total_reg;
    assign fade_long    = {fade_reg, 1'b0} > {1'b0, pulse_reg};
    assign before_start = p_reg < start_reg;
    assign period       = {1'b0, pulse_reg} + {1'b0, pause_reg};
    assign need_div     = in_buf && !fade_long && !before_start && (period != '0);
    assign frame_offset = p_reg - start_reg;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign trial      = {rem_reg, dvd_reg[DW-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    assign rem_step   = trial_ge ? trial_diff[CB:0] : trial[CB:0];

    // Pulse evaluation from quotient (pulse number) and remainder (phase).
    assign idx       = quo_reg[CB-1:0];
    assign idx_ok    = idx < CB'(count_reg);
    assign phase_lo  = rem_reg[CB-1:0];
    assign start_pos = p_reg - phase_lo;
    assign end_sum   = {1'b0, start_pos} + {1'b0, pulse_reg};
    assign clip      = end_sum >= {1'b0, total_reg};
    assign end_pos   = clip ? ({1'b0, total_reg} - (CB+1)'(1)) : end_sum;
    assign open_gate = idx_ok && ({1'b0, p_reg} < end_pos);
    assign k2_full   = end_pos - {1'b0, p_reg};

    // Gain multiplier on the magnitude of the running result.
    assign gain_k    = cmd.sel_k2 ? k2_reg : k_reg;
    assign mag       = cur_reg[SB-1] ? (-cur_reg) : cur_reg;
    assign prod_full = DW'(mag) * DW'(gain_k);

    // Quotient of a gain division with the sign restored.
    assign quo_lo   = quo_reg[SB-1:0];
    assign gain_res = neg_reg ? (-quo_lo) : quo_lo;

    // Status toward the controller.
    assign status.need_div = need_div;
    assign status.div_done = (cnt_reg == '0);
    assign status.need_in  = gate_reg && apply_in_reg;
    assign status.need_out = gate_reg && apply_out_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= CB'(RST_START_OFFSET);
            pulse_reg <= CB'(RST_PULSE_LEN);
            pause_reg <= CB'(RST_PAUSE_LEN);
            fade_reg  <= CB'(RST_FADE_LEN);
            count_reg <= PULSE_COUNT_BITS'(RST_PULSE_COUNT);
            total_reg <= CB'(RST_TOTAL_FRAMES);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_OFFSET: start_reg <= cfg_data;
                REG_PULSE_LEN:    pulse_reg <= cfg_data;
                REG_PAUSE_LEN:    pause_reg <= cfg_data;
                REG_FADE_LEN:     fade_reg  <= cfg_data;
                REG_PULSE_COUNT:  count_reg <= cfg_data[PULSE_COUNT_BITS-1:0];
                REG_TOTAL_FRAMES: total_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Frame counter, divider step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                frame_pos_reg <= frame_pos_next;
            end

            if (cmd.classify)
            begin
                cnt_reg <= CW'(CB);
            end
            else if (cmd.gain_load)
            begin
                cnt_reg <= CW'(SB);
            end
            else if (cmd.div_step && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current beat.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_reg    <= p_in;
            samp_reg <= sample;
        end

        // Settle the silent, pass-through and before-start cases; load the position division.
        if (cmd.classify)
        begin
            gate_reg    <= in_buf && fade_long;
            cur_reg     <= (in_buf && fade_long) ? samp_reg : '0;
            rem_reg     <= '0;
            dvd_reg     <= {frame_offset, {SB{1'b0}}};
            divisor_reg <= period;
            quo_reg     <= '0;
        end

        if (cmd.eval)
        begin
            gate_reg      <= open_gate;
            cur_reg       <= open_gate ? samp_reg : '0;
            k_reg         <= phase_lo;
            k2_reg        <= k2_full[CB-1:0];
            apply_in_reg  <= phase_lo < fade_reg;
            apply_out_reg <= k2_full[CB-1:0] < fade_reg;
        end

        if (cmd.mul)
        begin
            prod_reg <= prod_full;
            neg_reg  <= cur_reg[SB-1];
        end

        // The high product bits are already below the divisor, so only SB steps remain.
        if (cmd.gain_load)
        begin
            rem_reg     <= {1'b0, prod_reg[DW-1:SB]};
            dvd_reg     <= {prod_reg[SB-1:0], {CB{1'b0}}};
            divisor_reg <= {1'b0, fade_reg};
            quo_reg     <= '0;
        end

        if (cmd.div_step && (cnt_reg != '0))
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], trial_ge};
        end

        if (cmd.gain_store)
        begin
            cur_reg <= gain_res;
        end

        if (cmd.out_load)
        begin
            shaped_reg   <= cur_reg;
            gate_out_reg <= gate_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shaped_sample = shaped_reg;
    assign gate_open     = gate_out_reg;

    // Checks on the datapath.
    `PTEG_ASSERT_IMP(a_out_load_free, cmd.out_load, !out_valid_reg || !out_stall, "output overwritten")
    `PTEG_ASSERT_IMP(a_gain_fits, cmd.gain_store, quo_reg[SAMPLE_BITS-1] == 1'b0, "gain overflow")
    `PTEG_ASSERT_NEXT(a_load_busy, cmd.gain_load, cnt_reg != '0, "divider not started by load")

endmodule

[rtl/core/pteg_ctrl.sv]
// Controller of the pulse train gate: sequences classification, position division,
// the two fade gains and the output handoff. Uses pteg_pkg.
`include "assert_macros.svh"

module pteg_ctrl
    import pteg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        second_reg;
    logic        second_next;

    // State register and gain selector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        cmd.sel_k2  = second_reg;
        in_stall    = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = status.need_div ? ST_POS_DIV : ST_DONE;
            end
            ST_POS_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_POS_EVAL;
                end
            end
            ST_POS_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_FADE_IN;
            end
            ST_FADE_IN:
            begin
                if (status.need_in)
                begin
                    second_next = 1'b0;
                    state_next  = ST_MUL;
                end
                else
                begin
                    state_next = ST_FADE_OUT;
                end
            end
            ST_FADE_OUT:
            begin
                if (status.need_out)
                begin
                    second_next = 1'b1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_GAIN_LOAD;
            end
            ST_GAIN_LOAD:
            begin
                cmd.gain_load = 1'b1;
                state_next    = ST_GAIN_DIV;
            end
            ST_GAIN_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_GAIN_STORE;
                end
            end
            ST_GAIN_STORE:
            begin
                cmd.gain_store = 1'b1;
                state_next     = second_reg ? ST_DONE : ST_FADE_OUT;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencing.
    `PTEG_ASSERT_NEXT(a_accept_to_classify, in_valid && !in_stall, state_reg == ST_CLASSIFY, "accepted beat not classified")
    `PTEG_ASSERT_IMP(a_store_after_div, state_reg == ST_GAIN_STORE, status.div_done, "gain stored before division ended")
    `PTEG_ASSERT_IMP(a_busy_stalls, state_reg != ST_IDLE, in_stall, "input open while busy")

endmodule

[tb/sv/tb.sv]
// Testbench for pulse_train_envelope_gate_unit: frames are pushed through the gate and every
// shaped beat is checked against a cycle-free prediction. Depends on pteg_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb;
    import pteg_pkg::*;

    localparam int SW = DEF_SAMPLE_BITS;
    localparam int CW = DEF_COUNT_BITS;
    localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 1;
    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam int RANDOM_FRAMES = 1550;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic signed [SW-1:0] shaped;
        logic                 gate;
    } shaped_beat_t;

    // Tracks the gate settings and the frame counter, and holds the shaped beats
    // still owed by the unit.
    class pulse_gate_tracker;
        longint unsigned start_offset, pulse_len, pause_len, fade_len;
        longint unsigned pulse_count, total_frames, frame_pos;
        shaped_beat_t    pending_shaped[$];
        int              failures;

        function new();
            start_offset = RST_START_OFFSET;
            pulse_len    = RST_PULSE_LEN;
            pause_len    = RST_PAUSE_LEN;
            fade_len     = RST_FADE_LEN;
            pulse_count  = RST_PULSE_COUNT;
            total_frames = RST_TOTAL_FRAMES;
            frame_pos    = 0;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CW-1:0] data);
            case (idx)
                REG_START_OFFSET: start_offset = data;
                REG_PULSE_LEN:    pulse_len    = data;
                REG_PAUSE_LEN:    pause_len    = data;
                REG_FADE_LEN:     fade_len     = data;
                REG_PULSE_COUNT:  pulse_count  = data[PULSE_COUNT_BITS-1:0];
                REG_TOTAL_FRAMES: total_frames = data;
                default: ;
            endcase
        endfunction

        // Magnitude times k over den, truncated toward zero, sign restored.
        function longint scale_toward_zero(longint v, longint unsigned k, longint unsigned den);
            longint unsigned mag;
            if (den == 0)
                return v;
            mag = (v < 0) ? -v : v;
            mag = (mag * k) / den;
            return (v < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        // Works out the shaped beat for one frame and advances the frame counter.
        function shaped_beat_t shape_frame(logic signed [SW-1:0] smp, logic rst_frame);
            longint unsigned p, d, period, idx, s, e, k, k2;
            longint          v, res;
            shaped_beat_t    r;
            p = rst_frame ? 0 : frame_pos;
            v = smp;
            res = 0;
            r.gate = 1'b0;
            if (p < total_frames) begin
                if (fade_len * 2 > pulse_len) begin
                    res = v;
                    r.gate = 1'b1;
                end else if (p >= start_offset) begin
                    d = p - start_offset;
                    period = pulse_len + pause_len;
                    if (period != 0) begin
                        idx = d / period;
                        if (idx < pulse_count) begin
                            s = start_offset + idx * period;
                            e = s + pulse_len;
                            if (e >= total_frames)
                                e = total_frames - 1;
                            if (p < e) begin
                                k = p - s;
                                k2 = e - p;
                                r.gate = 1'b1;
                                res = v;
                                if (k < fade_len)
                                    res = scale_toward_zero(res, k, fade_len);
                                if (k2 < fade_len)
                                    res = scale_toward_zero(res, k2, fade_len);
                            end
                        end
                    end
                end
            end
            frame_pos = (p < COUNT_MAX) ? p + 1 : COUNT_MAX;
            r.shaped = res[SW-1:0];
            return r;
        endfunction

        function void take_frame(logic signed [SW-1:0] smp, logic rst_frame);
            pending_shaped.insert(pending_shaped.size(), shape_frame(smp, rst_frame));
        endfunction

        function void check_shaped(logic signed [SW-1:0] got_s, logic got_g);
            shaped_beat_t want;
            if (pending_shaped.size() == 0) begin
                $display("%0t: unexpected beat: shaped_sample %0d gate_open %0b",
                         $time, got_s, got_g);
                failures++;
                return;
            end
            want = pending_shaped.pop_front();
            if (got_s !== want.shaped) begin
                $display("%0t: shaped_sample expected %0d actual %0d",
                         $time, want.shaped, got_s);
                failures++;
            end
            if (got_g !== want.gate) begin
                $display("%0t: gate_open expected %0b actual %0b", $time, want.gate, got_g);
                failures++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CW-1:0]           cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SW-1:0]    sample;
    logic                    restart;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SW-1:0]    shaped_sample;
    logic                    gate_open;

    pulse_gate_tracker tracker = new();
    int frames_taken = 0;
    int burst_left = 0;
    int random_frames = 0;

    pulse_train_envelope_gate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall),
        .shaped_sample(shaped_sample), .gate_open(gate_open)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver: changes its stall pattern every so often, and holds off once for a long
    // stretch so that the unit fills up and stalls its input.
    initial
    begin
        int  mode, mode_left, hold_left;
        bit  hold_done;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && frames_taken >= HOLD_AFTER) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Each accepted output beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_shaped(shaped_sample, gate_open);
    end

    // Writes one register and mirrors it into the tracker.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input longint unsigned so, input longint unsigned pl,
                                  input longint unsigned pa, input longint unsigned fl,
                                  input longint unsigned pc, input longint unsigned tf);
        write_register(REG_START_OFFSET, so[CW-1:0]);
        write_register(REG_PULSE_LEN,    pl[CW-1:0]);
        write_register(REG_PAUSE_LEN,    pa[CW-1:0]);
        write_register(REG_FADE_LEN,     fl[CW-1:0]);
        write_register(REG_PULSE_COUNT,  pc[CW-1:0]);
        write_register(REG_TOTAL_FRAMES, tf[CW-1:0]);
    endtask

    // Offers one frame beat; the sender works in bursts with gaps between them.
    task automatic send_frame(input logic signed [SW-1:0] smp, input logic rst_frame);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= smp;
        restart  <= rst_frame;
        do @(posedge clk); while (in_stall);
        tracker.take_frame(smp, rst_frame);
        frames_taken++;
        burst_left--;
    endtask

    // Lowers valid and waits until every owed beat has come back.
    task automatic drain_gate();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_shaped.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return SW'(-1);
            4: return SW'($signed($urandom_range(0, 6)) - 3);
            default: return SW'($urandom());
        endcase
    endfunction

    // Random frames under the current settings, with occasional restarts.
    task automatic run_frames(input int n, input int restart_odds, input bit first_restart);
        logic rst_frame;
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                rst_frame = first_restart;
            else
                rst_frame = ($urandom_range(0, restart_odds - 1) == 0);
            send_frame(pick_sample(), rst_frame);
            random_frames++;
        end
    endtask

    // Small random settings, so pulses, fades, pauses and the buffer end all come up.
    task automatic settle_small();
        longint unsigned so, pl, pa, fl, pc, tf, period;
        pl = $urandom_range(1, 40);
        case ($urandom_range(0, 5))
            0: fl = 0;
            1: fl = pl / 2;
            2: fl = pl / 2 + 1;
            default: fl = $urandom_range(0, int'(pl / 2));
        endcase
        pa = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
        so = $urandom_range(0, 25);
        pc = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 7);
        // Upper bits of the count write are dropped by the register.
        if ($urandom_range(0, 4) == 0)
            pc = pc | (longint'($urandom_range(1, 4095)) << PULSE_COUNT_BITS);
        period = pl + pa;
        if ($urandom_range(0, 2) == 0)
            tf = so + $urandom_range(0, 4) * period + $urandom_range(0, int'(pl));
        else
            tf = $urandom_range(1, 300);
        apply_settings(so, pl, pa, fl, pc, tf);
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                           CW'($urandom()));
    endtask

    // Each register at zero, its maximum or a small value.
    function automatic longint unsigned mixed_value(longint unsigned top);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return top;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    initial
    begin
        int phase, n;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_START_OFFSET;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        restart   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Settings after reset: start of the first fade-in, extreme samples, a restart.
        send_frame(SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MIN, 1'b0);
        send_frame(SW'(-1), 1'b0);
        send_frame(SW'(1), 1'b0);
        send_frame(SAMPLE_MAX, 1'b1);
        drain_gate();

        // Silence before the start, both ramps, a pause, a clipped second pulse and
        // frames past the buffer; spare register indexes must be ignored.
        apply_settings(2, 6, 2, 2, 2, 12);
        write_register(REG_SPARE_LO, '1);
        write_register(REG_SPARE_HI, '1);
        for (int i = 0; i < 14; i++)
            send_frame((i % 4 == 0) ? SAMPLE_MAX : (i % 4 == 1) ? SAMPLE_MIN :
                       (i % 4 == 2) ? SW'(-1) : SW'($urandom()), i == 0);
        drain_gate();

        // Fade longer than half the pulse passes every frame unchanged.
        write_register(REG_FADE_LEN, CW'(4));
        send_frame(SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MAX, 1'b0);
        send_frame(SW'(-1), 1'b0);
        drain_gate();

        // A zero period opens no pulse.
        apply_settings(0, 0, 0, 0, 2, 12);
        send_frame(SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, 1'b0);
        send_frame(SW'(-1), 1'b0);
        drain_gate();

        // Random phases, each under fresh settings.
        phase = 0;
        while (random_frames < RANDOM_FRAMES) begin
            case (phase)
                0: begin
                    apply_settings(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 255, COUNT_MAX);
                    n = 30;
                end
                1: begin
                    apply_settings(0, COUNT_MAX, COUNT_MAX, COUNT_MAX / 2, 255, COUNT_MAX);
                    n = 30;
                end
                2: begin
                    apply_settings(0, 0, 0, 0, 0, 0);
                    n = 20;
                end
                3: begin
                    apply_settings(COUNT_MAX, 0, 0, 0, 0, COUNT_MAX);
                    n = 20;
                end
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        apply_settings(mixed_value(COUNT_MAX), mixed_value(COUNT_MAX),
                                       mixed_value(COUNT_MAX), mixed_value(COUNT_MAX),
                                       mixed_value(255), mixed_value(COUNT_MAX));
                        n = 40;
                    end else begin
                        settle_small();
                        n = $urandom_range(60, 140);
                    end
                end
            endcase
            run_frames(n, $urandom_range(30, 350), $urandom_range(0, 3) != 0);
            drain_gate();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
